// ===== hw/rtl/ptgm_pkg.sv =====
// shared types, constants and helper functions of the pad to tile grid mapper
`default_nettype none
package ptgm_pkg;

    localparam int GRID_W  = 8;
    localparam int COORD_W = 12;
    localparam int DIV_W   = 27;
    localparam int CFG_W   = 8;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_OWN_X     = 3'd0;
    localparam logic [IDX_W-1:0] REG_OWN_Y     = 3'd1;
    localparam logic [IDX_W-1:0] REG_PARTNER_X = 3'd2;
    localparam logic [IDX_W-1:0] REG_PARTNER_Y = 3'd3;
    localparam logic [IDX_W-1:0] REG_MARGIN_X  = 3'd4;
    localparam logic [IDX_W-1:0] REG_MARGIN_Y  = 3'd5;

    typedef struct packed {
        logic [1:0]         pad_quarter;
        logic [2:0]         pad_region;
        logic [COORD_W-1:0] pad_x;
        logic [COORD_W-1:0] pad_y;
    } pad_t;

    typedef struct packed {
        logic [1:0]         tile_quarter;
        logic [2:0]         tile_region;
        logic [COORD_W-1:0] tile_x;
        logic [COORD_W-1:0] tile_y;
        logic               last_tile;
        logic               truncated;
    } tile_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [GRID_W-1:0] divisor;
    } div_req_t;

    // region of one coordinate from its distance to the origin in grid cells
    function automatic logic [2:0] axis_region(logic [DIV_W-1:0] c, logic [GRID_W-1:0] g);
        logic [DIV_W-1:0] d;
        logic [DIV_W-1:0] g1;
        begin
            d  = c - DIV_W'(1);
            g1 = DIV_W'(g);
            if (d < g1)
                axis_region = 3'd0;
            else if (d < (g1 << 1))
                axis_region = 3'd1;
            else if (d < (g1 << 2))
                axis_region = 3'd2;
            else if (d < (g1 << 3))
                axis_region = 3'd3;
            else
                axis_region = 3'd4;
        end
    endfunction

    function automatic logic [2:0] fine_region(logic [DIV_W-1:0] x, logic [DIV_W-1:0] y,
                                               logic [GRID_W-1:0] gx, logic [GRID_W-1:0] gy);
        logic [2:0] rx;
        logic [2:0] ry;
        begin
            rx = axis_region(x, gx);
            ry = axis_region(y, gy);
            fine_region = (rx > ry) ? rx : ry;
        end
    endfunction

    // log2 of the cell scale of a region
    function automatic logic [2:0] scale_shift(logic [2:0] r);
        begin
            scale_shift = (r <= 3'd1) ? 3'd0 : r - 3'd1;
        end
    endfunction

    function automatic logic [GRID_W-1:0] nz(logic [GRID_W-1:0] g);
        begin
            nz = (g == '0) ? GRID_W'(1) : g;
        end
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ptgm_div.sv =====
// shared restoring divider, one quotient bit per cycle while busy; a start while busy is ignored
`default_nettype none
module ptgm_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire ptgm_pkg::div_req_t         req,
    output logic                            done,
    output logic [ptgm_pkg::DIV_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(ptgm_pkg::DIV_W);

    logic                          busy_reg;
    logic                          done_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [ptgm_pkg::GRID_W-1:0]   rem_reg;
    logic [ptgm_pkg::GRID_W-1:0]   dvs_reg;
    logic [ptgm_pkg::DIV_W-1:0]    quo_reg;
    logic [ptgm_pkg::GRID_W:0]     trial;
    logic                          qbit;
    logic [ptgm_pkg::GRID_W:0]     diff;

    always_comb
    begin
        trial = {rem_reg, quo_reg[ptgm_pkg::DIV_W-1]};
        qbit  = (trial >= {1'b0, dvs_reg});
        diff  = trial - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(ptgm_pkg::DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            rem_reg <= '0;
            dvs_reg <= req.divisor;
            quo_reg <= req.dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= qbit ? diff[ptgm_pkg::GRID_W-1:0] : trial[ptgm_pkg::GRID_W-1:0];
            quo_reg <= {quo_reg[ptgm_pkg::DIV_W-2:0], qbit};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

`ifndef NO_ASSERTIONS
    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a running division");
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held longer than one cycle");
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg <= CNT_W'(ptgm_pkg::DIV_W - 1))
        else $error("divider step count past the last quotient bit");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/pad_to_tile_grid_mapper_top.sv =====
// top level: configuration registers and tile scan sequencer around a shared divider
// before tile 1: 4 divisions (RX, RY, DX, DY), the bound, clamp and step states, then 2 divisions
// each further tile takes 2 divisions (TX, TY) on the divider
// a pad with an empty area drops busy after the clamp state with no tile
// one pad at a time; busy drops in the cycle the last tile strobe is shown; reset: grids 1,
// margins 0, sequencer idle
`default_nettype none
module pad_to_tile_grid_mapper_top #(
    parameter int MAX_TILES = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire ptgm_pkg::pad_t                 pad,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ptgm_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [ptgm_pkg::CFG_W-1:0]     cfg_data,
    output logic                                tile_valid,
    output ptgm_pkg::tile_t                     tile
);

    localparam int CW = $clog2(MAX_TILES + 1);
    localparam int DW = ptgm_pkg::DIV_W;
    localparam int GW = ptgm_pkg::GRID_W;

    typedef enum logic [2:0] {
        S_IDLE, S_ISSUE, S_WAIT, S_BOUND, S_CLAMP, S_STEP
    } state_t;

    typedef enum logic [2:0] {
        OP_RX, OP_RY, OP_DX, OP_DY, OP_TX, OP_TY
    } op_t;

    state_t state_reg;
    op_t    op_reg;

    logic [GW-1:0] own_x_reg, own_y_reg, par_x_reg, par_y_reg;
    logic [2:0]    mar_x_reg, mar_y_reg;

    ptgm_pkg::pad_t  pad_reg;
    logic [GW-1:0]   rx_reg, ry_reg, dx_reg, dy_reg;
    logic [DW-1:0]   max_x_reg, max_y_reg, min_x_reg, min_y_reg;
    logic [17:0]     span_x_reg, span_y_reg;
    logic [DW-1:0]   x_reg, y_reg;
    logic [3:0]      step_reg;
    logic [CW-1:0]   n_reg;
    logic [ptgm_pkg::COORD_W-1:0] tx_reg;
    logic            tile_valid_reg;
    ptgm_pkg::tile_t tile_reg;

    logic [GW-1:0]   ogx, ogy, pgx, pgy, fgx, fgy;
    logic [2:0]      psh;
    logic [2:0]      reg_cur;
    logic [2:0]      tsh;
    ptgm_pkg::div_req_t div_req;
    logic            div_done;
    logic [DW-1:0]   div_q;
    logic [DW-1:0]   qp1;
    logic [GW-1:0]   q8;
    logic [12:0]     ext_x, ext_y;
    logic [18:0]     shl_x, shl_y;
    logic [13:0]     rxs, rys;
    logic [3:0]      odd_x, odd_y;
    logic [DW+1:0]   dmin_x, dmin_y;
    logic [DW:0]     x_nx, y_nx;
    logic            has_x, has_y, nxt, at_max;

    always_comb
    begin
        ogx = ptgm_pkg::nz(own_x_reg);
        ogy = ptgm_pkg::nz(own_y_reg);
        pgx = ptgm_pkg::nz(par_x_reg);
        pgy = ptgm_pkg::nz(par_y_reg);
        fgx = (ogx > pgx) ? ogx : pgx;
        fgy = (ogy > pgy) ? ogy : pgy;
        psh = ptgm_pkg::scale_shift(pad_reg.pad_region);
        reg_cur = ptgm_pkg::fine_region(x_reg, y_reg, fgx, fgy);
        tsh = ptgm_pkg::scale_shift(reg_cur);
        qp1 = div_q + DW'(1);
        q8  = (div_q[GW-1:0] == '0) ? GW'(1) : div_q[GW-1:0];

        ext_x = 13'(pad_reg.pad_x) + 13'(mar_x_reg);
        ext_y = 13'(pad_reg.pad_y) + 13'(mar_y_reg);
        shl_x = 19'(ext_x) << psh;
        shl_y = 19'(ext_y) << psh;
        rxs   = 14'(rx_reg) << psh;
        rys   = 14'(ry_reg) << psh;
        odd_x = {mar_x_reg, 1'b1};
        odd_y = {mar_y_reg, 1'b1};
        dmin_x = {2'b00, max_x_reg} - (DW+2)'(span_x_reg) + (DW+2)'(1);
        dmin_y = {2'b00, max_y_reg} - (DW+2)'(span_y_reg) + (DW+2)'(1);

        x_nx  = {1'b0, x_reg} + (DW+1)'(step_reg);
        y_nx  = {1'b0, y_reg} + (DW+1)'(step_reg);
        has_x = (x_nx <= {1'b0, max_x_reg});
        has_y = (y_nx <= {1'b0, max_y_reg});
        nxt   = has_x || has_y;
        at_max = (n_reg == CW'(MAX_TILES - 1));

        div_req.start = (state_reg == S_ISSUE);
        unique case (op_reg)
            OP_RX:
            begin
                div_req.dividend = DW'(ogx);
                div_req.divisor  = pgx;
            end
            OP_RY:
            begin
                div_req.dividend = DW'(ogy);
                div_req.divisor  = pgy;
            end
            OP_DX:
            begin
                div_req.dividend = DW'(fgx);
                div_req.divisor  = ogx;
            end
            OP_DY:
            begin
                div_req.dividend = DW'(fgy);
                div_req.divisor  = ogy;
            end
            OP_TX:
            begin
                div_req.dividend = (x_reg - DW'(1)) >> tsh;
                div_req.divisor  = dx_reg;
            end
            OP_TY:
            begin
                div_req.dividend = (y_reg - DW'(1)) >> tsh;
                div_req.divisor  = dy_reg;
            end
            default:
            begin
                div_req.dividend = '0;
                div_req.divisor  = GW'(1);
            end
        endcase
    end

    ptgm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_x_reg <= GW'(1);
            own_y_reg <= GW'(1);
            par_x_reg <= GW'(1);
            par_y_reg <= GW'(1);
            mar_x_reg <= '0;
            mar_y_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ptgm_pkg::REG_OWN_X:     own_x_reg <= cfg_data;
                ptgm_pkg::REG_OWN_Y:     own_y_reg <= cfg_data;
                ptgm_pkg::REG_PARTNER_X: par_x_reg <= cfg_data;
                ptgm_pkg::REG_PARTNER_Y: par_y_reg <= cfg_data;
                ptgm_pkg::REG_MARGIN_X:  mar_x_reg <= cfg_data[2:0];
                ptgm_pkg::REG_MARGIN_Y:  mar_y_reg <= cfg_data[2:0];
                default:                 ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_RX;
            tile_valid_reg <= 1'b0;
        end
        else
        begin
            tile_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg    <= OP_RX;
                        state_reg <= S_ISSUE;
                    end
                end
                S_ISSUE:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (div_done)
                    begin
                        unique case (op_reg)
                            OP_RX:
                            begin
                                op_reg    <= OP_RY;
                                state_reg <= S_ISSUE;
                            end
                            OP_RY:
                            begin
                                op_reg    <= OP_DX;
                                state_reg <= S_ISSUE;
                            end
                            OP_DX:
                            begin
                                op_reg    <= OP_DY;
                                state_reg <= S_ISSUE;
                            end
                            OP_DY:
                            begin
                                state_reg <= S_BOUND;
                            end
                            OP_TX:
                            begin
                                op_reg    <= OP_TY;
                                state_reg <= S_ISSUE;
                            end
                            OP_TY:
                            begin
                                tile_valid_reg <= 1'b1;
                                op_reg         <= OP_TX;
                                state_reg      <= (!nxt || at_max) ? S_IDLE : S_ISSUE;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_BOUND:
                begin
                    state_reg <= S_CLAMP;
                end
                S_CLAMP:
                begin
                    state_reg <= (max_x_reg == '0 || max_y_reg == '0) ? S_IDLE : S_STEP;
                end
                S_STEP:
                begin
                    op_reg    <= OP_TX;
                    state_reg <= S_ISSUE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
            pad_reg <= pad;
        if (state_reg == S_WAIT && div_done)
        begin
            unique case (op_reg)
                OP_RX: rx_reg <= q8;
                OP_RY: ry_reg <= q8;
                OP_DX: dx_reg <= div_q[GW-1:0];
                OP_DY: dy_reg <= div_q[GW-1:0];
                OP_TX: tx_reg <= qp1[ptgm_pkg::COORD_W-1:0];
                OP_TY:
                begin
                    tile_reg.tile_quarter <= pad_reg.pad_quarter;
                    tile_reg.tile_region  <= reg_cur;
                    tile_reg.tile_x       <= tx_reg;
                    tile_reg.tile_y       <= qp1[ptgm_pkg::COORD_W-1:0];
                    tile_reg.last_tile    <= !nxt || at_max;
                    tile_reg.truncated    <= nxt && at_max;
                    n_reg <= n_reg + CW'(1);
                    if (has_y)
                        y_reg <= y_nx[DW-1:0];
                    else
                    begin
                        x_reg <= x_nx[DW-1:0];
                        y_reg <= min_y_reg;
                    end
                end
                default: ;
            endcase
        end
        if (state_reg == S_BOUND)
        begin
            max_x_reg  <= DW'(shl_x * rx_reg);
            max_y_reg  <= DW'(shl_y * ry_reg);
            span_x_reg <= 18'(rxs * odd_x);
            span_y_reg <= 18'(rys * odd_y);
        end
        if (state_reg == S_CLAMP)
        begin
            min_x_reg <= (dmin_x[DW+1] || dmin_x == '0) ? DW'(1) : dmin_x[DW-1:0];
            min_y_reg <= (dmin_y[DW+1] || dmin_y == '0) ? DW'(1) : dmin_y[DW-1:0];
        end
        if (state_reg == S_STEP)
        begin
            x_reg    <= min_x_reg;
            y_reg    <= min_y_reg;
            n_reg    <= '0;
            step_reg <= 4'd1 << ptgm_pkg::scale_shift(
                            ptgm_pkg::fine_region(min_x_reg, min_y_reg, fgx, fgy));
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign cfg_ready  = 1'b1;
    assign tile_valid = tile_valid_reg;
    assign tile       = tile_reg;

`ifndef NO_ASSERTIONS
    a_tile_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tile_valid |-> $past(busy))
        else $error("tile strobe outside a pad");
    a_trunc_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        tile_valid && tile.truncated |-> tile.last_tile)
        else $error("truncated flag on a tile that is not last");
    a_last_ends_pad: assert property (@(posedge clk) disable iff (!rst_n)
        tile_valid && tile.last_tile |-> !busy)
        else $error("sequencer still busy after last tile");
    a_start_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted pad did not start the sequencer");
`endif

endmodule
`default_nettype wire

// ===== tb/ptgm_checker.sv =====
// checker: tracks configuration beats, predicts the tile list of each pad and compares tiles
module ptgm_checker
    import ptgm_pkg::*;
#(
    parameter int MAX_TILES = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic             busy,
    input  wire pad_t             pad,
    input  wire logic             cfg_valid,
    input  wire logic             cfg_ready,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic             tile_valid,
    input  wire tile_t            tile,
    output int                    errors,
    output int                    pending,
    output int                    tiles_seen,
    output int                    cut_lists
);

    logic [7:0] own_gx, own_gy, ptn_gx, ptn_gy;
    logic [2:0] mar_x, mar_y;
    tile_t      expected_tiles[$];

    function automatic longint cell_scale(longint r);
        return (r <= 1) ? 64'd1 : (64'd1 << (r - 1));
    endfunction

    function automatic longint grid_or_one(logic [7:0] g);
        return (g == 8'd0) ? 64'd1 : longint'(g);
    endfunction

    function automatic longint coord_region(longint c, longint g);
        longint q;
        q = (c - 1) / g;
        if (q < 1) return 0;
        if (q == 1) return 1;
        if (q <= 3) return 2;
        if (q <= 7) return 3;
        return 4;
    endfunction

    function automatic longint point_region(longint x, longint y, longint gx, longint gy);
        longint a, b;
        a = coord_region(x, gx);
        b = coord_region(y, gy);
        return (a > b) ? a : b;
    endfunction

    function automatic void predict_tiles(pad_t p);
        longint ogx, ogy, pgx, pgy, fgx, fgy, rx, ry, ps, mx, my;
        longint hi_x, hi_y, lo_x, lo_y, dx, dy, stride, x, y, r, s;
        int     n;
        bit     cut;
        tile_t  t;
        ogx = grid_or_one(own_gx);
        ogy = grid_or_one(own_gy);
        pgx = grid_or_one(ptn_gx);
        pgy = grid_or_one(ptn_gy);
        fgx = (ogx > pgx) ? ogx : pgx;
        fgy = (ogy > pgy) ? ogy : pgy;
        rx = ogx / pgx;
        ry = ogy / pgy;
        if (rx == 0) rx = 1;
        if (ry == 0) ry = 1;
        mx = mar_x;
        my = mar_y;
        ps = cell_scale(p.pad_region);
        hi_x = (longint'(p.pad_x) + mx) * ps * rx;
        hi_y = (longint'(p.pad_y) + my) * ps * ry;
        lo_x = hi_x - ps * rx * (2 * mx + 1) + 1;
        lo_y = hi_y - ps * ry * (2 * my + 1) + 1;
        if (lo_x < 1) lo_x = 1;
        if (lo_y < 1) lo_y = 1;
        dx = fgx / ogx;
        dy = fgy / ogy;
        stride = cell_scale(point_region(lo_x, lo_y, fgx, fgy));
        n = 0;
        cut = 0;
        for (x = lo_x; x <= hi_x && !cut; x += stride) begin
            for (y = lo_y; y <= hi_y; y += stride) begin
                if (n >= MAX_TILES) begin
                    cut = 1;
                    break;
                end
                r = point_region(x, y, fgx, fgy);
                s = cell_scale(r);
                t.tile_quarter = p.pad_quarter;
                t.tile_region  = 3'(r);
                t.tile_x       = 12'((x - 1) / s / dx + 1);
                t.tile_y       = 12'((y - 1) / s / dy + 1);
                t.last_tile    = 1'b0;
                t.truncated    = 1'b0;
                expected_tiles = {expected_tiles, t};
                n++;
            end
        end
        if (n > 0) begin
            expected_tiles[$].last_tile = 1'b1;
            expected_tiles[$].truncated = cut;
            if (cut) cut_lists++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        tile_t e;
        if (!rst_n) begin
            own_gx <= 8'd1;
            own_gy <= 8'd1;
            ptn_gx <= 8'd1;
            ptn_gy <= 8'd1;
            mar_x  <= 3'd0;
            mar_y  <= 3'd0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_OWN_X:     own_gx <= cfg_data;
                    REG_OWN_Y:     own_gy <= cfg_data;
                    REG_PARTNER_X: ptn_gx <= cfg_data;
                    REG_PARTNER_Y: ptn_gy <= cfg_data;
                    REG_MARGIN_X:  mar_x  <= cfg_data[2:0];
                    REG_MARGIN_Y:  mar_y  <= cfg_data[2:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                predict_tiles(pad);
            if (tile_valid) begin
                tiles_seen++;
                if (expected_tiles.size() == 0) begin
                    $error("tile with no expectation waiting: %p", tile);
                    errors++;
                end
                else begin
                    e = expected_tiles.pop_front();
                    if (tile.tile_quarter !== e.tile_quarter) begin
                        $error("tile_quarter expected %0d got %0d", e.tile_quarter,
                               tile.tile_quarter);
                        errors++;
                    end
                    if (tile.tile_region !== e.tile_region) begin
                        $error("tile_region expected %0d got %0d", e.tile_region,
                               tile.tile_region);
                        errors++;
                    end
                    if (tile.tile_x !== e.tile_x) begin
                        $error("tile_x expected %0d got %0d", e.tile_x, tile.tile_x);
                        errors++;
                    end
                    if (tile.tile_y !== e.tile_y) begin
                        $error("tile_y expected %0d got %0d", e.tile_y, tile.tile_y);
                        errors++;
                    end
                    if (tile.last_tile !== e.last_tile) begin
                        $error("last_tile expected %0d got %0d", e.last_tile, tile.last_tile);
                        errors++;
                    end
                    if (tile.truncated !== e.truncated) begin
                        $error("truncated expected %0d got %0d", e.truncated, tile.truncated);
                        errors++;
                    end
                end
            end
        end
        pending = expected_tiles.size();
    end

    initial begin
        errors     = 0;
        pending    = 0;
        tiles_seen = 0;
        cut_lists  = 0;
    end

endmodule

// ===== tb/tb_pad_to_tile_grid_mapper_top.sv =====
// testbench top: clock, reset, pad and configuration stimulus, verdict
module tb_pad_to_tile_grid_mapper_top;
    import ptgm_pkg::*;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    pad_t             pad = '0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             tile_valid;
    tile_t            tile;
    int               errors, pending, tiles_seen, cut_lists;
    int               pads_sent = 0;
    int               idle_pct = 18;

    always #5 clk = ~clk;

    pad_to_tile_grid_mapper_top u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .pad(pad),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .tile_valid(tile_valid), .tile(tile)
    );

    ptgm_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .pad(pad),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .tile_valid(tile_valid), .tile(tile),
        .errors(errors), .pending(pending), .tiles_seen(tiles_seen), .cut_lists(cut_lists)
    );

    task automatic send_pad(logic [1:0] q, logic [2:0] r, logic [11:0] x, logic [11:0] y);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct && gap < 20)
            gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        pad   <= '{pad_quarter: q, pad_region: r, pad_x: x, pad_y: y};
        do @(posedge clk); while (busy);
        pads_sent++;
    endtask

    task automatic settle();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0 || busy);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_grids(logic [7:0] ox, logic [7:0] oy, logic [7:0] px, logic [7:0] py,
                             logic [2:0] mx, logic [2:0] my);
        settle();
        write_reg(REG_OWN_X, ox);
        write_reg(REG_OWN_Y, oy);
        write_reg(REG_PARTNER_X, px);
        write_reg(REG_PARTNER_Y, py);
        write_reg(REG_MARGIN_X, {5'd0, mx});
        write_reg(REG_MARGIN_Y, {5'd0, my});
        @(posedge clk);
    endtask

    task automatic random_pads(int count);
        logic [2:0]  r;
        logic [11:0] x, y;
        repeat (count) begin
            if (pads_sent < 140)
                idle_pct = 18;
            else if (pads_sent < 270)
                idle_pct = 70;
            else
                idle_pct = 0;
            r = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
            x = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 40));
            y = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 40));
            send_pad(2'($urandom), r, x, y);
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset-like grids, field extremes, empty area, every quarter and region
        set_grids(8'd1, 8'd1, 8'd1, 8'd1, 3'd0, 3'd0);
        send_pad(2'd0, 3'd0, 12'd0, 12'd0);
        send_pad(2'd1, 3'd0, 12'd0, 12'd5);
        send_pad(2'd2, 3'd0, 12'd4095, 12'd4095);
        send_pad(2'd3, 3'd1, 12'd1, 12'd1);
        send_pad(2'd0, 3'd2, 12'd3, 12'd2);
        send_pad(2'd1, 3'd3, 12'd2, 12'd7);
        send_pad(2'd2, 3'd4, 12'd9, 12'd1);
        send_pad(2'd3, 3'd7, 12'd4095, 12'd4095);
        set_grids(8'd0, 8'd255, 8'd3, 8'd0, 3'd7, 3'd7);
        send_pad(2'd0, 3'd0, 12'd0, 12'd0);
        send_pad(2'd3, 3'd4, 12'd40, 12'd2);
        send_pad(2'd1, 3'd0, 12'd4095, 12'd1);
        set_grids(8'd255, 8'd4, 8'd255, 8'd2, 3'd1, 3'd0);
        send_pad(2'd2, 3'd1, 12'd2730, 12'd1365);
        send_pad(2'd1, 3'd2, 12'd1, 12'd4095);
        send_pad(2'd0, 3'd5, 12'd17, 12'd3);
        send_pad(2'd3, 3'd6, 12'd0, 12'd2);
        set_grids(8'd255, 8'd255, 8'd1, 8'd1, 3'd0, 3'd0);
        send_pad(2'd1, 3'd0, 12'd1, 12'd1);
        send_pad(2'd2, 3'd3, 12'd4095, 12'd0);

        // random pads under a spread of grid settings
        set_grids(8'd1, 8'd1, 8'd1, 8'd1, 3'd0, 3'd0);
        random_pads(70);
        set_grids(8'd8, 8'd4, 8'd4, 8'd8, 3'd1, 3'd0);
        random_pads(70);
        set_grids(8'd2, 8'd3, 8'd6, 8'd1, 3'd0, 3'd1);
        random_pads(70);
        set_grids(8'($urandom_range(1, 20)), 8'($urandom_range(1, 20)),
                  8'($urandom_range(1, 20)), 8'($urandom_range(1, 20)), 3'd1, 3'd1);
        random_pads(70);
        set_grids(8'd1, 8'd2, 8'd200, 8'd1, 3'd0, 3'd0);
        random_pads(60);
        set_grids(8'd0, 8'd0, 8'd0, 8'd0, 3'd7, 3'd7);
        random_pads(20);

        settle();
        $display("covered %0d pads and %0d tiles, %0d lists cut at the maximum",
                 pads_sent, tiles_seen, cut_lists);
        $display("grid settings included zero, one and 255 grids and margins 0 to 7");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #80_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
